### sv/mmc_pkg.sv
package mmc_pkg;

  // input commands
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_MOVE_X = 3'd1;
  localparam logic [2:0] CMD_MOVE_Y = 3'd2;
  localparam logic [2:0] CMD_WHEEL  = 3'd3;
  localparam logic [2:0] CMD_BUTTON = 3'd4;

  // result kinds
  localparam logic [1:0] EV_MOVE  = 2'd0;
  localparam logic [1:0] EV_CLICK = 2'd1;
  localparam logic [1:0] EV_WHEEL = 2'd2;

  localparam int NUM_BUTTONS = 3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] value;
    logic [1:0]         button_index;
    logic [39:0]        time_sec;
    logic [29:0]        time_nsec;
  } item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic signed [23:0] delta_x;
    logic signed [23:0] delta_y;
    logic [1:0]         which_button;
    logic               press;
    logic signed [15:0] wheel_step;
    logic [39:0]        stamp_sec;
    logic [29:0]        stamp_nsec;
    logic               final_res;
  } result_t;

  // handshake between the decision stage and the output register
  typedef struct packed {
    logic res_valid;
    logic out_free;
  } res_hs_t;

endpackage

### sv/mmc_if.sv
interface mmc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [15:0] value;
  logic [1:0]         button_index;
  logic [39:0]        time_sec;
  logic [29:0]        time_nsec;

  modport source (output valid, command, value, button_index, time_sec, time_nsec,
                  input ready);
  modport sink (input valid, command, value, button_index, time_sec, time_nsec,
                output ready);
endinterface

interface mmc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [23:0] delta_x;
  logic signed [23:0] delta_y;
  logic [1:0]         which_button;
  logic               press;
  logic signed [15:0] wheel_step;
  logic [39:0]        stamp_sec;
  logic [29:0]        stamp_nsec;
  logic               final_res;

  modport source (output valid, event_kind, delta_x, delta_y, which_button, press,
                  wheel_step, stamp_sec, stamp_nsec, final_res,
                  input ready);
  modport sink (input valid, event_kind, delta_x, delta_y, which_button, press,
                wheel_step, stamp_sec, stamp_nsec, final_res,
                output ready);
endinterface

### sv/mmc_in_reg.sv
module mmc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mmc_pkg::item_t  in_item,
  input  logic            consume,
  output logic            item_valid,
  output mmc_pkg::item_t  item
);

  logic           valid_r;
  logic           valid_nxt;
  mmc_pkg::item_t item_r;

  // free when empty or when the held item finishes this cycle
  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### sv/mmc_core.sv
module mmc_core #(
  parameter int ACC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  mmc_pkg::item_t    item,
  output logic              consume,
  output mmc_pkg::res_hs_t  hs_out,
  input  logic              out_free,
  output mmc_pkg::result_t  res
);

  localparam int WIDE_BITS = (ACC_BITS > 24) ? ACC_BITS : 24;
  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = -24'sh800000;

  logic signed [ACC_BITS-1:0] sum_x_r, sum_x_nxt;
  logic signed [ACC_BITS-1:0] sum_y_r, sum_y_nxt;
  logic                       pending_r, pending_nxt;
  logic [mmc_pkg::NUM_BUTTONS-1:0] levels_r, levels_nxt;

  logic value_nz;
  logic btn_ok;
  logic level_chg;
  logic has_event;
  logic need_move;
  logic emit;
  logic fire;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] acc,
    input logic signed [15:0]         d
  );
    logic signed [ACC_BITS:0] s;
    s = (ACC_BITS+1)'(acc) + (ACC_BITS+1)'(d);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      sat_add = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      sat_add = s[ACC_BITS-1:0];
    end
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [ACC_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(v);
    if (w > WIDE_BITS'(OUT_MAX)) begin
      clamp24 = OUT_MAX;
    end else if (w < WIDE_BITS'(OUT_MIN)) begin
      clamp24 = OUT_MIN;
    end else begin
      clamp24 = 24'(w);
    end
  endfunction

  // decode the held item against current state
  assign value_nz  = (item.value != 16'sd0);
  assign btn_ok    = (item.button_index < 2'(mmc_pkg::NUM_BUTTONS));
  assign level_chg = btn_ok && (value_nz != levels_r[item.button_index]);
  assign has_event = ((item.command == mmc_pkg::CMD_WHEEL) && value_nz) ||
                     ((item.command == mmc_pkg::CMD_BUTTON) && level_chg);
  assign need_move = pending_r && ((item.command == mmc_pkg::CMD_TICK) || has_event);
  assign emit      = item_valid && (need_move || has_event);
  assign fire      = emit && out_free;

  // a flushed move leaves the item in place; the next cycle sees no pending
  // motion and sends the wheel or click once the output register is free
  assign consume = item_valid && (!emit || (fire && !(need_move && has_event)));

  assign hs_out.res_valid = emit;
  assign hs_out.out_free  = out_free;

  always_comb begin
    res              = '0;
    res.stamp_sec    = item.time_sec;
    res.stamp_nsec   = item.time_nsec;
    if (need_move) begin
      res.event_kind = mmc_pkg::EV_MOVE;
      res.delta_x    = clamp24(sum_x_r);
      res.delta_y    = clamp24(sum_y_r);
      res.final_res  = !has_event;
    end else if (item.command == mmc_pkg::CMD_WHEEL) begin
      res.event_kind = mmc_pkg::EV_WHEEL;
      res.wheel_step = item.value;
      res.final_res  = 1'b1;
    end else begin
      res.event_kind   = mmc_pkg::EV_CLICK;
      res.which_button = item.button_index;
      res.press        = value_nz;
      res.final_res    = 1'b1;
    end
  end

  always_comb begin
    sum_x_nxt   = sum_x_r;
    sum_y_nxt   = sum_y_r;
    pending_nxt = pending_r;
    levels_nxt  = levels_r;
    if (item_valid && value_nz && (item.command == mmc_pkg::CMD_MOVE_X)) begin
      sum_x_nxt   = sat_add(sum_x_r, item.value);
      pending_nxt = 1'b1;
    end
    if (item_valid && value_nz && (item.command == mmc_pkg::CMD_MOVE_Y)) begin
      sum_y_nxt   = sat_add(sum_y_r, item.value);
      pending_nxt = 1'b1;
    end
    if (fire && need_move) begin
      sum_x_nxt   = '0;
      sum_y_nxt   = '0;
      pending_nxt = 1'b0;
    end
    if (fire && !need_move && (item.command == mmc_pkg::CMD_BUTTON)) begin
      levels_nxt[item.button_index] = value_nz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      pending_r <= 1'b0;
      levels_r  <= '0;
    end else begin
      sum_x_r   <= sum_x_nxt;
      sum_y_r   <= sum_y_nxt;
      pending_r <= pending_nxt;
      levels_r  <= levels_nxt;
    end
  end

`ifndef SYNTHESIS
  a_move_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.event_kind == mmc_pkg::EV_MOVE) |-> pending_r)
    else $error("move issued without pending motion");

  a_move_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.event_kind == mmc_pkg::EV_MOVE) |=> !pending_r)
    else $error("pending motion survived a move");

  a_nonfinal_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !res.final_res) |-> !consume)
    else $error("item released before its last result");

  a_nonfinal_followed: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !res.final_res) |=>
      (emit && res.event_kind != mmc_pkg::EV_MOVE && res.final_res))
    else $error("flushed move not followed by its event");
`endif

endmodule

### sv/mmc_out_reg.sv
module mmc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  mmc_pkg::res_hs_t  hs_in,
  input  mmc_pkg::result_t  res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output mmc_pkg::result_t  out_res
);

  logic              valid_r;
  logic              valid_nxt;
  mmc_pkg::result_t  res_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (hs_in.res_valid && hs_in.out_free) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hs_in.res_valid && hs_in.out_free) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### sv/mouse_motion_coalescer.sv
// Pointer-event coalescer. Each input transaction is a report tick, an x or y
// motion delta, a wheel step or a button level, with a timestamp. Motion is
// summed into saturating ACC_BITS-wide accumulators; a tick sends one move
// result if motion is pending, and a wheel step or a changed button level
// first flushes pending motion as a move and then sends its own result.
// final_res marks the last result of an input. An input is taken into an
// input register, decided there against the accumulator and button state,
// and its results pass through one output register, which registers the
// first result once it is decided. The input register takes a new input as
// soon as the held one is consumed; a wheel or click that flushes a move stays
// there while both results leave through the single output register, one at
// a time. While a result waits at the output, motion and other silent inputs
// keep flowing; an input with a result waits in the input register until the
// output register frees.
module mouse_motion_coalescer #(
  parameter int ACC_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  mmc_in_if.sink           in_ch,
  mmc_out_if.source        out_ch
);

  mmc_pkg::item_t    in_item;
  mmc_pkg::item_t    item;
  mmc_pkg::result_t  res;
  mmc_pkg::result_t  out_res;
  mmc_pkg::res_hs_t  hs;
  logic              item_valid;
  logic              consume;
  logic              out_free;
  logic              in_ready;
  logic              out_valid;

  // gather the incoming transaction into one word
  assign in_item.command      = in_ch.command;
  assign in_item.value        = in_ch.value;
  assign in_item.button_index = in_ch.button_index;
  assign in_item.time_sec     = in_ch.time_sec;
  assign in_item.time_nsec    = in_ch.time_nsec;
  assign in_ch.ready          = in_ready;

  // input register: holds an item until all its results are out
  mmc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  // accumulators, button levels and the choice of result
  mmc_core #(
    .ACC_BITS (ACC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .consume    (consume),
    .hs_out     (hs),
    .out_free   (out_free),
    .res        (res)
  );

  // result register toward the sink
  mmc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .hs_in     (hs),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.event_kind   = out_res.event_kind;
  assign out_ch.delta_x      = out_res.delta_x;
  assign out_ch.delta_y      = out_res.delta_y;
  assign out_ch.which_button = out_res.which_button;
  assign out_ch.press        = out_res.press;
  assign out_ch.wheel_step   = out_res.wheel_step;
  assign out_ch.stamp_sec    = out_res.stamp_sec;
  assign out_ch.stamp_nsec   = out_res.stamp_nsec;
  assign out_ch.final_res    = out_res.final_res;

endmodule

### dv/tb_mouse_motion_coalescer.sv
`timescale 1ns / 100ps

module tb_mouse_motion_coalescer;

  localparam int ACC_BITS = 24;
  localparam int N_RANDOM = 1420;

  // tracks what the block must send: its own copy of the accumulators,
  // the pending flag and the button levels, plus the queue of expected events
  class event_tracker #(int ACC_W = 24);
    longint  acc_x;
    longint  acc_y;
    bit      moving;
    bit      held [mmc_pkg::NUM_BUTTONS];
    mmc_pkg::result_t expected_events [$];
    int      errors;
    int      n_items;
    int      n_silent;
    int      n_checked;
    int      n_move;
    int      n_click;
    int      n_wheel;
    int      n_clamped;

    function new();
      acc_x = 0;
      acc_y = 0;
      moving = 1'b0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    // signed saturation to a given width
    function longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void queue_event(logic [1:0] kind, longint dx, longint dy, logic [1:0] btn,
                              logic prs, logic signed [15:0] whl, mmc_pkg::item_t it);
      mmc_pkg::result_t r;
      r = '0;
      r.event_kind   = kind;
      r.delta_x      = 24'(clip(dx, 24));
      r.delta_y      = 24'(clip(dy, 24));
      r.which_button = btn;
      r.press        = prs;
      r.wheel_step   = whl;
      r.stamp_sec    = it.time_sec;
      r.stamp_nsec   = it.time_nsec;
      r.final_res    = 1'b0;
      expected_events.push_back(r);
    endfunction

    // pending motion leaves as one move, stamped with the current input
    function void flush_motion(mmc_pkg::item_t it);
      if (moving) begin
        queue_event(mmc_pkg::EV_MOVE, acc_x, acc_y, 2'd0, 1'b0, 16'sd0, it);
        acc_x = 0;
        acc_y = 0;
        moving = 1'b0;
      end
    endfunction

    function void note_input(mmc_pkg::item_t it);
      int     n_prior;
      longint s;
      logic   lvl;
      mmc_pkg::result_t r;
      n_prior = expected_events.size();
      n_items++;
      case (it.command)
        mmc_pkg::CMD_TICK: flush_motion(it);
        mmc_pkg::CMD_MOVE_X: begin
          if (it.value != 0) begin
            s = acc_x + longint'(it.value);
            acc_x = clip(s, ACC_W);
            if (acc_x != s) n_clamped++;
            moving = 1'b1;
          end
        end
        mmc_pkg::CMD_MOVE_Y: begin
          if (it.value != 0) begin
            s = acc_y + longint'(it.value);
            acc_y = clip(s, ACC_W);
            if (acc_y != s) n_clamped++;
            moving = 1'b1;
          end
        end
        mmc_pkg::CMD_WHEEL: begin
          if (it.value != 0) begin
            flush_motion(it);
            queue_event(mmc_pkg::EV_WHEEL, 0, 0, 2'd0, 1'b0, it.value, it);
          end
        end
        mmc_pkg::CMD_BUTTON: begin
          if (it.button_index < mmc_pkg::NUM_BUTTONS) begin
            lvl = (it.value != 0);
            if (lvl != held[it.button_index]) begin
              flush_motion(it);
              queue_event(mmc_pkg::EV_CLICK, 0, 0, it.button_index, lvl, 16'sd0, it);
              held[it.button_index] = lvl;
            end
          end
        end
        default: ;
      endcase
      // last event of this input carries the final marker
      if (expected_events.size() > n_prior) begin
        r = expected_events.pop_back();
        r.final_res = 1'b1;
        expected_events.push_back(r);
      end else begin
        n_silent++;
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("event %0d field %s got %0h expected %0h", n_checked, name, got,
                         want));
    endtask

    task check_event(mmc_pkg::result_t got);
      mmc_pkg::result_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("event with nothing expected, kind %0d", got.event_kind));
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", got.event_kind, want.event_kind);
      compare_field("delta_x", got.delta_x, want.delta_x);
      compare_field("delta_y", got.delta_y, want.delta_y);
      compare_field("which_button", got.which_button, want.which_button);
      compare_field("press", got.press, want.press);
      compare_field("wheel_step", got.wheel_step, want.wheel_step);
      compare_field("stamp_sec", got.stamp_sec, want.stamp_sec);
      compare_field("stamp_nsec", got.stamp_nsec, want.stamp_nsec);
      compare_field("final_res", got.final_res, want.final_res);
      n_checked++;
      case (want.event_kind)
        mmc_pkg::EV_MOVE:  n_move++;
        mmc_pkg::EV_CLICK: n_click++;
        default:           n_wheel++;
      endcase
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  // quiet: no idling on either side; gap_mode: sender idles in bursts
  bit quiet;
  bit gap_mode;

  event_tracker #(ACC_BITS) book;

  mmc_in_if  in_ch ();
  mmc_out_if out_ch ();

  mouse_motion_coalescer #(.ACC_BITS(ACC_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // observe both channels at the clock edge, pre-update values
  always @(posedge clk) begin : watch
    mmc_pkg::result_t got;
    mmc_pkg::item_t   took;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.event_kind   = out_ch.event_kind;
        got.delta_x      = out_ch.delta_x;
        got.delta_y      = out_ch.delta_y;
        got.which_button = out_ch.which_button;
        got.press        = out_ch.press;
        got.wheel_step   = out_ch.wheel_step;
        got.stamp_sec    = out_ch.stamp_sec;
        got.stamp_nsec   = out_ch.stamp_nsec;
        got.final_res    = out_ch.final_res;
        book.check_event(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        took.command      = in_ch.command;
        took.value        = in_ch.value;
        took.button_index = in_ch.button_index;
        took.time_sec     = in_ch.time_sec;
        took.time_nsec    = in_ch.time_nsec;
        book.note_input(took);
      end
    end
  end

  // receiver pacing: ready runs, some long, broken by stalls unless quiet is set
  initial begin : sink_pacing
    int run;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      if (!quiet) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(1, 17);
        repeat (stall) @(posedge clk);
      end
    end
  end

  // random timestamp; now and then nanoseconds beyond one second
  function automatic mmc_pkg::item_t make_item(logic [2:0] cmd, logic signed [15:0] val,
                                               logic [1:0] btn);
    mmc_pkg::item_t it;
    it.command      = cmd;
    it.value        = val;
    it.button_index = btn;
    it.time_sec     = {8'($urandom()), 32'($urandom())};
    if ($urandom_range(0, 7) == 0)
      it.time_nsec = 30'($urandom());
    else
      it.time_nsec = 30'($urandom_range(0, 999999999));
    return it;
  endfunction

  // mostly small motion with ticks, wheel and button traffic mixed in
  function automatic mmc_pkg::item_t random_item();
    int                 pick;
    logic [2:0]         cmd;
    logic signed [15:0] val;
    logic [1:0]         btn;
    pick = $urandom_range(0, 99);
    btn = 2'($urandom_range(0, 2));
    val = 16'($urandom());
    if (pick < 60) begin
      cmd = (pick < 30) ? mmc_pkg::CMD_MOVE_X : mmc_pkg::CMD_MOVE_Y;
      case ($urandom_range(0, 9))
        0:       val = 16'sd0;
        1, 2:    val = 16'($urandom());
        default: val = 16'(int'($urandom_range(0, 254)) - 127);
      endcase
    end else if (pick < 75) begin
      cmd = mmc_pkg::CMD_TICK;
    end else if (pick < 83) begin
      cmd = mmc_pkg::CMD_WHEEL;
      case ($urandom_range(0, 9))
        0:       val = 16'sd0;
        1, 2:    val = 16'($urandom());
        default: val = 16'(int'($urandom_range(0, 5)) - 3 + (($urandom_range(0, 1) != 0) ? 0 : 1));
      endcase
    end else if (pick < 95) begin
      cmd = mmc_pkg::CMD_BUTTON;
      if ($urandom_range(0, 9) == 0) btn = 2'd3;
      if ($urandom_range(0, 9) < 7) val = 16'($urandom_range(0, 1));
    end else begin
      cmd = 3'($urandom_range(5, 7));
    end
    return make_item(cmd, val, btn);
  endfunction

  // hold valid until the block takes the transaction
  task automatic send_item(mmc_pkg::item_t it);
    if (!quiet && gap_mode && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= it.command;
    in_ch.value        <= it.value;
    in_ch.button_index <= it.button_index;
    in_ch.time_sec     <= it.time_sec;
    in_ch.time_nsec    <= it.time_nsec;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send(logic [2:0] cmd, logic signed [15:0] val, logic [1:0] btn);
    send_item(make_item(cmd, val, btn));
  endtask

  // stop sending and let every expected event come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (book.expected_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // long run of one extreme delta on one axis, drives the sum into saturation,
  // then backs off a little and ticks the move out
  task automatic surge(logic [2:0] cmd, logic signed [15:0] val, int n);
    repeat (n) send(cmd, val, 2'd0);
    send(cmd, -(val >>> 12), 2'd0);
    send(mmc_pkg::CMD_TICK, 16'sd0, 2'd0);
  endtask

  initial begin : run_timeout
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    mmc_pkg::item_t d;
    book = new();
    quiet = 1'b0;
    gap_mode = 1'b1;
    rst_n <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= mmc_pkg::CMD_TICK;
    in_ch.value        <= '0;
    in_ch.button_index <= '0;
    in_ch.time_sec     <= '0;
    in_ch.time_nsec    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick with nothing pending, zero stamp
    d = make_item(mmc_pkg::CMD_TICK, 16'sd0, 2'd0);
    d.time_sec = '0;
    d.time_nsec = '0;
    send_item(d);
    // zero motion and zero wheel are dropped
    send(mmc_pkg::CMD_MOVE_X, 16'sd0, 2'd0);
    send(mmc_pkg::CMD_WHEEL, 16'sd0, 2'd0);
    send(mmc_pkg::CMD_TICK, 16'sd0, 2'd0);
    // deltas that cancel still give a move of zero
    send(mmc_pkg::CMD_MOVE_X, 16'sd5, 2'd0);
    send(mmc_pkg::CMD_MOVE_X, -16'sd5, 2'd0);
    send(mmc_pkg::CMD_TICK, 16'sd0, 2'd0);
    // extreme deltas flushed by a wheel step
    send(mmc_pkg::CMD_MOVE_Y, 16'sh8000, 2'd0);
    send(mmc_pkg::CMD_MOVE_X, 16'sd32767, 2'd0);
    send(mmc_pkg::CMD_WHEEL, 16'sd1, 2'd0);
    send(mmc_pkg::CMD_WHEEL, 16'sh8000, 2'd0);
    send(mmc_pkg::CMD_WHEEL, 16'sd32767, 2'd0);
    // press, unchanged level, negative nonzero level counts as pressed
    send(mmc_pkg::CMD_BUTTON, 16'sd1, 2'd0);
    send(mmc_pkg::CMD_BUTTON, 16'sd1, 2'd0);
    send(mmc_pkg::CMD_BUTTON, 16'sh8000, 2'd1);
    // click that flushes motion first
    send(mmc_pkg::CMD_MOVE_Y, 16'sd3, 2'd0);
    send(mmc_pkg::CMD_BUTTON, 16'sd1, 2'd2);
    // bad button index and unused commands
    send(mmc_pkg::CMD_BUTTON, 16'sd1, 2'd3);
    send(3'd5, 16'sd1, 2'd1);
    send(3'd6, 16'sd1, 2'd2);
    send(3'd7, 16'sd1, 2'd3);
    // largest stamp, nanoseconds out of range
    d = make_item(mmc_pkg::CMD_WHEEL, -16'sd1, 2'd0);
    d.time_sec = '1;
    d.time_nsec = '1;
    send_item(d);
    // releases
    send(mmc_pkg::CMD_BUTTON, 16'sd0, 2'd0);
    send(mmc_pkg::CMD_BUTTON, 16'sd0, 2'd1);
    send(mmc_pkg::CMD_BUTTON, 16'sd0, 2'd2);
    send(mmc_pkg::CMD_TICK, 16'sd0, 2'd0);
    settle();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) gap_mode = ($urandom_range(0, 2) != 0);
      // last part of the run without any idling
      if (i == N_RANDOM * 85 / 100) quiet = 1'b1;
      if (i == 300) surge(mmc_pkg::CMD_MOVE_X, 16'sd32767, 262);
      if (i == 700) begin
        // hold off until the block has drained, then saturate low
        settle();
        surge(mmc_pkg::CMD_MOVE_Y, 16'sh8000, 262);
      end
      send_item(random_item());
    end
    settle();

    $display("covered %0d input transactions (%0d without events), %0d events checked",
             book.n_items, book.n_silent, book.n_checked);
    $display("events: %0d move, %0d click, %0d wheel; accumulator clamped %0d times",
             book.n_move, book.n_click, book.n_wheel, book.n_clamped);
    if (book.errors == 0 && book.expected_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
